// ===== rtl/ffra_pkg.sv =====
package ffra_pkg;

  localparam int unsigned MAX_FREE_RANGES_DEF = 64;
  localparam logic [31:0] CAPACITY_RESET      = 32'd16777216;
  localparam int unsigned WORD_W              = 32;
  localparam int unsigned ENTRY_W             = 2 * WORD_W;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO     = 2'd1,
    ST_NOMEM    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_START, S_RD, S_CHK, S_FREE_DEC,
    S_DN_CHK, S_DN_WR, S_UP_CHK, S_UP_WR, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    WR_INIT, WR_SHRINK, WR_BOTH, WR_NEXT, WR_PREV, WR_NEW, WR_SHIFT
  } wr_sel_t;

  typedef enum logic [1:0] {
    RD_IDX, RD_DN, RD_UP
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    step;
    logic    sh_ld_idx;
    logic    sh_ld_cnt;
    logic    sh_inc;
    logic    sh_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_one;
    logic    res_set;
    status_t res_code;
    logic    res_grant;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic zero;
    logic idx_lt_cnt;
    logic fits;
    logic exact;
    logic start_le;
    logic join_next;
    logic join_prev;
    logic full;
    logic dn_more;
    logic up_more;
  } dp_stat_t;

endpackage

// ===== rtl/ffra_ram.sv =====
module ffra_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ffra_ctrl.sv =====
module ffra_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               out_fire,
  input  ffra_pkg::dp_stat_t stat,
  output ffra_pkg::ctrl_cmd_t cmd,
  output logic               in_rdy,
  output logic               out_vld
);

  ffra_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffra_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffra_pkg::S_INIT: state_nxt = ffra_pkg::S_IDLE;
      ffra_pkg::S_IDLE: if (in_fire) state_nxt = ffra_pkg::S_START;
      ffra_pkg::S_START: state_nxt = stat.zero ? ffra_pkg::S_OUT : ffra_pkg::S_RD;
      ffra_pkg::S_RD: begin
        if (stat.idx_lt_cnt) state_nxt = ffra_pkg::S_CHK;
        else if (stat.op == ffra_pkg::OP_ALLOC) state_nxt = ffra_pkg::S_OUT;
        else state_nxt = ffra_pkg::S_FREE_DEC;
      end
      ffra_pkg::S_CHK: begin
        if (stat.op == ffra_pkg::OP_ALLOC) begin
          if (!stat.fits) state_nxt = ffra_pkg::S_RD;
          else if (stat.exact) state_nxt = ffra_pkg::S_DN_CHK;
          else state_nxt = ffra_pkg::S_OUT;
        end else begin
          state_nxt = stat.start_le ? ffra_pkg::S_RD : ffra_pkg::S_FREE_DEC;
        end
      end
      ffra_pkg::S_FREE_DEC: begin
        priority if (stat.join_next && stat.join_prev) state_nxt = ffra_pkg::S_DN_CHK;
        else if (stat.join_next || stat.join_prev) state_nxt = ffra_pkg::S_OUT;
        else if (stat.full) state_nxt = ffra_pkg::S_OUT;
        else state_nxt = ffra_pkg::S_UP_CHK;
      end
      ffra_pkg::S_DN_CHK: state_nxt = stat.dn_more ? ffra_pkg::S_DN_WR : ffra_pkg::S_OUT;
      ffra_pkg::S_DN_WR:  state_nxt = ffra_pkg::S_DN_CHK;
      ffra_pkg::S_UP_CHK: state_nxt = stat.up_more ? ffra_pkg::S_UP_WR : ffra_pkg::S_OUT;
      ffra_pkg::S_UP_WR:  state_nxt = ffra_pkg::S_UP_CHK;
      ffra_pkg::S_OUT:    if (out_fire) state_nxt = ffra_pkg::S_IDLE;
      default:            state_nxt = ffra_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd          = '0;
    cmd.wr_sel   = ffra_pkg::WR_INIT;
    cmd.rd_sel   = ffra_pkg::RD_IDX;
    cmd.res_code = ffra_pkg::ST_OK;
    in_rdy       = 1'b0;
    out_vld      = 1'b0;
    unique case (state_r)
      ffra_pkg::S_INIT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = ffra_pkg::WR_INIT;
        cmd.cnt_one = 1'b1;
      end
      ffra_pkg::S_IDLE: begin
        in_rdy   = 1'b1;
        cmd.load = in_fire;
      end
      ffra_pkg::S_START: begin
        if (stat.zero) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ffra_pkg::ST_ZERO;
        end
      end
      ffra_pkg::S_RD: begin
        if (stat.idx_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ffra_pkg::RD_IDX;
        end else if (stat.op == ffra_pkg::OP_ALLOC) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ffra_pkg::ST_NOMEM;
        end
      end
      ffra_pkg::S_CHK: begin
        if (stat.op == ffra_pkg::OP_ALLOC) begin
          if (stat.fits) begin
            cmd.res_set   = 1'b1;
            cmd.res_grant = 1'b1;
            if (stat.exact) begin
              cmd.sh_ld_idx = 1'b1;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = ffra_pkg::WR_SHRINK;
            end
          end else begin
            cmd.step = 1'b1;
          end
        end else if (stat.start_le) begin
          cmd.step = 1'b1;
        end
      end
      ffra_pkg::S_FREE_DEC: begin
        cmd.res_set = 1'b1;
        priority if (stat.join_next && stat.join_prev) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_sel    = ffra_pkg::WR_BOTH;
          cmd.sh_ld_idx = 1'b1;
        end else if (stat.join_next) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = ffra_pkg::WR_NEXT;
        end else if (stat.join_prev) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = ffra_pkg::WR_PREV;
        end else if (stat.full) begin
          cmd.res_code = ffra_pkg::ST_FULL;
        end else begin
          cmd.sh_ld_cnt = 1'b1;
        end
      end
      ffra_pkg::S_DN_CHK: begin
        if (stat.dn_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ffra_pkg::RD_DN;
        end else begin
          cmd.cnt_dec = 1'b1;
        end
      end
      ffra_pkg::S_DN_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ffra_pkg::WR_SHIFT;
        cmd.sh_inc = 1'b1;
      end
      ffra_pkg::S_UP_CHK: begin
        if (stat.up_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ffra_pkg::RD_UP;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = ffra_pkg::WR_NEW;
          cmd.cnt_inc = 1'b1;
        end
      end
      ffra_pkg::S_UP_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ffra_pkg::WR_SHIFT;
        cmd.sh_dec = 1'b1;
      end
      ffra_pkg::S_OUT: out_vld = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/ffra_dp.sv =====
module ffra_dp #(
  parameter int unsigned MAX_FREE_RANGES = ffra_pkg::MAX_FREE_RANGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data,
  input  logic                in_op,
  input  logic [31:0]         in_off,
  input  logic [31:0]         in_size,
  input  ffra_pkg::ctrl_cmd_t cmd,
  output ffra_pkg::dp_stat_t  stat,
  output logic [1:0]          res_status,
  output logic [31:0]         res_goff,
  output logic [31:0]         res_gsize
);

  localparam int unsigned AW = $clog2(MAX_FREE_RANGES);
  localparam int unsigned CW = $clog2(MAX_FREE_RANGES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FREE_RANGES);

  logic [31:0]   cap_r;
  logic          op_r;
  logic [31:0]   off_r, size_r;
  logic [CW-1:0] idx_r, sh_r, cnt_r;
  logic [31:0]   prev_start_r, prev_len_r;
  logic [1:0]    status_r;
  logic [31:0]   goff_r, gsize_r;

  logic                      we;
  logic [AW-1:0]             waddr, raddr;
  logic [ffra_pkg::ENTRY_W-1:0] wdata, rdata;
  logic [31:0]               q_start, q_len;
  logic [CW-1:0]             idx_m1, sh_p1, sh_m1;
  logic [32:0]               off_end, prev_end;
  logic [33:0]               sum_both, sum_next, sum_prev;

  assign q_start = rdata[31:0];
  assign q_len   = rdata[63:32];
  assign idx_m1  = idx_r - CW'(1);
  assign sh_p1   = sh_r + CW'(1);
  assign sh_m1   = sh_r - CW'(1);

  // end offsets and merged lengths without wrap
  assign off_end  = {1'b0, off_r} + {1'b0, size_r};
  assign prev_end = {1'b0, prev_start_r} + {1'b0, prev_len_r};
  assign sum_next = {2'b00, size_r} + {2'b00, q_len};
  assign sum_prev = {2'b00, size_r} + {2'b00, prev_len_r};
  assign sum_both = sum_prev + {2'b00, q_len};

  function automatic logic [31:0] sat32(input logic [33:0] v);
    return (|v[33:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // status towards the controller
  always_comb begin
    stat            = '0;
    stat.op         = ffra_pkg::op_t'(op_r);
    stat.zero       = (size_r == 32'd0);
    stat.idx_lt_cnt = (idx_r < cnt_r);
    stat.fits       = (q_len >= size_r);
    stat.exact      = (q_len == size_r);
    stat.start_le   = (q_start <= off_r);
    stat.join_next  = (idx_r < cnt_r) && (off_end == {1'b0, q_start});
    stat.join_prev  = (idx_r != '0) && (prev_end == {1'b0, off_r});
    stat.full       = (cnt_r >= MAX_CNT);
    stat.dn_more    = (sh_p1 < cnt_r);
    stat.up_more    = (sh_r > idx_r);
  end

  // table write port, configuration has priority
  always_comb begin
    we    = cmd.wr_en;
    waddr = idx_r[AW-1:0];
    wdata = rdata;
    if (cfg_we) begin
      we    = 1'b1;
      waddr = '0;
      wdata = {cfg_data, 32'd0};
    end else begin
      unique case (cmd.wr_sel)
        ffra_pkg::WR_INIT:   begin waddr = '0; wdata = {cap_r, 32'd0}; end
        ffra_pkg::WR_SHRINK: wdata = {q_len - size_r, q_start + size_r};
        ffra_pkg::WR_BOTH:   begin
          waddr = idx_m1[AW-1:0];
          wdata = {sat32(sum_both), prev_start_r};
        end
        ffra_pkg::WR_NEXT:   wdata = {sat32(sum_next), off_r};
        ffra_pkg::WR_PREV:   begin
          waddr = idx_m1[AW-1:0];
          wdata = {sat32(sum_prev), prev_start_r};
        end
        ffra_pkg::WR_NEW:    wdata = {size_r, off_r};
        ffra_pkg::WR_SHIFT:  begin waddr = sh_r[AW-1:0]; wdata = rdata; end
        default:             wdata = rdata;
      endcase
    end
  end

  // table read address
  always_comb begin
    unique case (cmd.rd_sel)
      ffra_pkg::RD_IDX: raddr = idx_r[AW-1:0];
      ffra_pkg::RD_DN:  raddr = sh_p1[AW-1:0];
      ffra_pkg::RD_UP:  raddr = sh_m1[AW-1:0];
      default:          raddr = idx_r[AW-1:0];
    endcase
  end

  ffra_ram #(
    .WIDTH(ffra_pkg::ENTRY_W),
    .DEPTH(MAX_FREE_RANGES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  // capacity and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= ffra_pkg::CAPACITY_RESET;
      cnt_r <= CW'(1);
    end else if (cfg_we) begin
      cap_r <= cfg_data;
      cnt_r <= CW'(1);
    end else if (cmd.cnt_one) begin
      cnt_r <= CW'(1);
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  // request, scan position and shift pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      off_r  <= in_off;
      size_r <= in_size;
      idx_r  <= '0;
    end else if (cmd.step) begin
      idx_r        <= idx_r + CW'(1);
      prev_start_r <= q_start;
      prev_len_r   <= q_len;
    end
    if (cmd.sh_ld_idx) begin
      sh_r <= idx_r;
    end else if (cmd.sh_ld_cnt) begin
      sh_r <= cnt_r;
    end else if (cmd.sh_inc) begin
      sh_r <= sh_p1;
    end else if (cmd.sh_dec) begin
      sh_r <= sh_m1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      status_r <= cmd.res_code;
      goff_r   <= cmd.res_grant ? q_start : 32'd0;
      gsize_r  <= cmd.res_grant ? size_r : 32'd0;
    end
  end

  assign res_status = status_r;
  assign res_goff   = goff_r;
  assign res_gsize  = gsize_r;

endmodule

// ===== rtl/first_fit_range_allocator_unit.sv =====
// First-fit range allocator with a sorted, coalescing free list.
// Input channel in_*: in_tuser is the operation (0 allocate, 1 free),
// in_tdata carries the range offset and size. One result item per request
// on out_*: out_tuser is the status, out_tdata the granted offset and size.
// Requests are handled one at a time: in_tready is high only while idle.
// Each request scans the table entries in order, and an insert, an exact
// removal or a merge of both neighbours also shifts the tail of the table.
// A zero-size request skips the scan.
// The registered table read paces both the scan and the shift.
// The result waits in the output register while out_tready is low; no new
// request is taken until it is delivered.
// After reset the init state writes the single range [0, 16777216) to the table.
// cfg_we writes the capacity and resets the list to [0, capacity) at once;
// write it only while idle.
module first_fit_range_allocator_unit #(
  parameter int unsigned MAX_FREE_RANGES = ffra_pkg::MAX_FREE_RANGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // range_offset[31:0], range_size[63:32]
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // granted_offset[31:0], granted_size[63:32]
  output logic [1:0]  out_tuser   // status
);

  ffra_pkg::ctrl_cmd_t cmd;
  ffra_pkg::dp_stat_t  stat;
  logic                in_rdy, out_vld;
  logic [1:0]          res_status;
  logic [31:0]         res_goff, res_gsize;

  assign in_tready  = in_rdy;
  assign out_tvalid = out_vld;
  assign out_tdata  = {res_gsize, res_goff};
  assign out_tuser  = res_status;

  ffra_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_tvalid && in_rdy),
    .out_fire(out_vld && out_tready),
    .stat    (stat),
    .cmd     (cmd),
    .in_rdy  (in_rdy),
    .out_vld (out_vld)
  );

  ffra_dp #(
    .MAX_FREE_RANGES(MAX_FREE_RANGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_op     (in_tuser),
    .in_off    (in_tdata[31:0]),
    .in_size   (in_tdata[63:32]),
    .cmd       (cmd),
    .stat      (stat),
    .res_status(res_status),
    .res_goff  (res_goff),
    .res_gsize (res_gsize)
  );

endmodule

// ===== tb/sv/first_fit_range_allocator_unit_tb.sv =====
`timescale 1ns / 100ps

module first_fit_range_allocator_unit_tb;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned DRAIN_CYCLES = 4 * TABLE_DEPTH + 40;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [31:0] start[TABLE_DEPTH];
    logic [31:0] len[TABLE_DEPTH];
    int unsigned count;
  } free_list_t;

  typedef struct {
    ffra_pkg::op_t op;
    logic [31:0]   offset;
    logic [31:0]   size;
  } request_t;

  typedef struct {
    ffra_pkg::status_t status;
    logic [31:0]       offset;
    logic [31:0]       size;
  } grant_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // range_offset[31:0], range_size[63:32]
  logic        in_tuser;   // operation
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // granted_offset[31:0], granted_size[63:32]
  logic [1:0]  out_tuser;  // status

  first_fit_range_allocator_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  free_list_t  plan_list;      // used while generating requests
  free_list_t  checker_list;   // advanced as the block accepts items
  request_t    pending_reqs[$];
  grant_t      expected_grants[$];
  grant_t      held_ranges[$];
  int unsigned mismatch_count;
  int unsigned results_seen;
  longint unsigned cycle_count;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned hold_left;
  logic        long_hold_done;

  // list reset to one range [0, capacity)
  function automatic void list_reset(inout free_list_t fl, input logic [31:0] capacity);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      fl.start[i] = '0;
      fl.len[i] = '0;
    end
    fl.len[0] = capacity;
    fl.count = 1;
  endfunction

  function automatic void list_remove(inout free_list_t fl, input int unsigned idx);
    for (int unsigned i = idx; i + 1 < fl.count; i++) begin
      fl.start[i] = fl.start[i + 1];
      fl.len[i] = fl.len[i + 1];
    end
    fl.count--;
  endfunction

  function automatic logic [31:0] sat_word(input logic [33:0] v);
    return (v > 34'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
  endfunction

  // first fit allocate or coalescing free, returns the expected result
  function automatic grant_t serve_request(inout free_list_t fl, input request_t rq);
    grant_t      g;
    int unsigned p;
    logic        join_next;
    logic        join_prev;
    g.status = ffra_pkg::ST_OK;
    g.offset = '0;
    g.size = '0;
    p = 0;
    join_next = 1'b0;
    join_prev = 1'b0;
    if (rq.size == 0) begin
      g.status = ffra_pkg::ST_ZERO;
      return g;
    end
    if (rq.op == ffra_pkg::OP_ALLOC) begin
      g.status = ffra_pkg::ST_NOMEM;
      for (int unsigned i = 0; i < fl.count; i++) begin
        if (fl.len[i] >= rq.size) begin
          g.status = ffra_pkg::ST_OK;
          g.offset = fl.start[i];
          g.size = rq.size;
          if (fl.len[i] == rq.size) begin
            list_remove(fl, i);
          end else begin
            fl.start[i] += rq.size;
            fl.len[i] -= rq.size;
          end
          break;
        end
      end
      return g;
    end
    // free: place after any range starting at or below the offset
    while (p < fl.count && fl.start[p] <= rq.offset) p++;
    if (p < fl.count)
      join_next = ({1'b0, rq.offset} + {1'b0, rq.size}) == {1'b0, fl.start[p]};
    if (p > 0)
      join_prev = ({1'b0, fl.start[p-1]} + {1'b0, fl.len[p-1]}) == {1'b0, rq.offset};
    if (join_next && join_prev) begin
      fl.len[p-1] = sat_word({2'b0, fl.len[p-1]} + {2'b0, rq.size} + {2'b0, fl.len[p]});
      list_remove(fl, p);
    end else if (join_next) begin
      fl.start[p] = rq.offset;
      fl.len[p] = sat_word({2'b0, rq.size} + {2'b0, fl.len[p]});
    end else if (join_prev) begin
      fl.len[p-1] = sat_word({2'b0, fl.len[p-1]} + {2'b0, rq.size});
    end else if (fl.count >= TABLE_DEPTH) begin
      g.status = ffra_pkg::ST_FULL;
    end else begin
      for (int unsigned i = fl.count; i > p; i--) begin
        fl.start[i] = fl.start[i-1];
        fl.len[i] = fl.len[i-1];
      end
      fl.start[p] = rq.offset;
      fl.len[p] = rq.size;
      fl.count++;
    end
    return g;
  endfunction

  // queue one request, tracking granted ranges for later frees
  task automatic issue(input ffra_pkg::op_t op, input logic [31:0] offset,
                       input logic [31:0] size);
    request_t rq;
    grant_t   g;
    rq.op = op;
    rq.offset = offset;
    rq.size = size;
    g = serve_request(plan_list, rq);
    if (op == ffra_pkg::OP_ALLOC && g.status == ffra_pkg::ST_OK)
      held_ranges = {held_ranges, g};
    pending_reqs = {pending_reqs, rq};
  endtask

  task automatic free_held();
    int unsigned k;
    grant_t      g;
    k = $urandom_range(0, held_ranges.size() - 1);
    g = held_ranges[k];
    held_ranges.delete(k);
    issue(ffra_pkg::OP_FREE, g.offset, g.size);
  endtask

  // wait until every queued item has been sent and answered
  task automatic drain();
    while (pending_reqs.size() != 0 || expected_grants.size() != 0 || in_tvalid)
      @(negedge clk);
  endtask

  // capacity write while idle, both lists follow
  task automatic set_capacity(input logic [31:0] capacity);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= capacity;
    @(posedge clk);
    cfg_we <= 1'b0;
    list_reset(plan_list, capacity);
    list_reset(checker_list, capacity);
    held_ranges.delete();
    @(posedge clk);
  endtask

  // mostly allocate and free-back traffic with some noise
  task automatic random_phase(input logic [31:0] capacity, input int unsigned n);
    int unsigned r;
    logic [31:0] top;
    top = (capacity >> 3) == 0 ? 32'd1 : (capacity >> 3);
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80 && r >= 45 && held_ranges.size() != 0) begin
        free_held();
      end else if (r < 80) begin
        if ($urandom_range(0, 3) == 0)
          issue(ffra_pkg::OP_ALLOC, $urandom, $urandom_range(1, 4));
        else
          issue(ffra_pkg::OP_ALLOC, $urandom, $urandom_range(1, top));
      end else begin
        case ($urandom_range(0, 3))
          0: issue(ffra_pkg::op_t'($urandom_range(0, 1)), $urandom, $urandom);
          1: issue(ffra_pkg::op_t'($urandom_range(0, 1)), $urandom, 32'd0);
          2: issue(ffra_pkg::op_t'($urandom_range(0, 1)), $urandom, 32'hFFFFFFFF);
          default: issue(ffra_pkg::op_t'($urandom_range(0, 1)), $urandom,
                         $urandom_range(1, 16));
        endcase
      end
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender: pops pending items, random gaps between them
  always @(posedge clk) begin
    logic    next_valid;
    grant_t  g;
    request_t rq;
    next_valid = in_tvalid;
    if (!rst_n) begin
      next_valid = 1'b0;
      send_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        rq.op = ffra_pkg::op_t'(in_tuser);
        rq.offset = in_tdata[31:0];
        rq.size = in_tdata[63:32];
        g = serve_request(checker_list, rq);
        expected_grants = {expected_grants, g};
      end
      if (!(in_tvalid && !in_tready)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          next_valid = 1'b0;
        end else if (pending_reqs.size() != 0) begin
          rq = pending_reqs.pop_front();
          in_tuser <= rq.op;
          in_tdata <= {rq.size, rq.offset};
          next_valid = 1'b1;
          case ($urandom_range(0, 19))
            0: send_gap <= $urandom_range(10, 40);
            1, 2, 3, 4: send_gap <= $urandom_range(1, 3);
            default: send_gap <= 0;
          endcase
        end else begin
          next_valid = 1'b0;
        end
      end
    end
    in_tvalid <= next_valid;
  end

  // receiver: random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      long_hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!long_hold_done && results_seen == 300) begin
      long_hold_done <= 1'b1;
      hold_left <= 600;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      case ($urandom_range(0, 19))
        0: stall_left <= $urandom_range(10, 40);
        1, 2, 3: stall_left <= $urandom_range(1, 3);
        default: stall_left <= 0;
      endcase
    end
  end

  // monitor: compare each result item with the oldest expectation
  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (expected_grants.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d offset %h size %h",
                   out_tuser, out_tdata[31:0], out_tdata[63:32]);
      end else begin
        g = expected_grants.pop_front();
        if (out_tuser !== g.status || out_tdata[31:0] !== g.offset ||
            out_tdata[63:32] !== g.size) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp status %0d offset %h size %h, got %0d %h %h",
                     g.status, g.offset, g.size,
                     out_tuser, out_tdata[31:0], out_tdata[63:32]);
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("first_fit_range_allocator_unit_tb failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    mismatch_count = 0;
    results_seen = 0;
    cycle_count = 0;
    send_gap = 0;
    list_reset(plan_list, ffra_pkg::CAPACITY_RESET);
    list_reset(checker_list, ffra_pkg::CAPACITY_RESET);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero size, no fit, exact use, merges, equal offsets
    issue(ffra_pkg::OP_ALLOC, 32'h0, 32'h0);
    issue(ffra_pkg::OP_ALLOC, 32'hFFFFFFFF, ffra_pkg::CAPACITY_RESET + 1);
    issue(ffra_pkg::OP_ALLOC, 32'h0, 32'h10);
    issue(ffra_pkg::OP_ALLOC, 32'h0, ffra_pkg::CAPACITY_RESET - 32'h10);
    issue(ffra_pkg::OP_ALLOC, 32'h0, 32'h1);
    issue(ffra_pkg::OP_FREE, 32'h0, 32'h0);
    issue(ffra_pkg::OP_FREE, 32'h10, 32'h20);
    issue(ffra_pkg::OP_FREE, 32'h0, 32'h10);
    issue(ffra_pkg::OP_FREE, 32'h30, 32'h10);
    issue(ffra_pkg::OP_FREE, 32'h100, 32'h1);
    issue(ffra_pkg::OP_FREE, 32'h100, 32'h2);
    issue(ffra_pkg::OP_FREE, 32'h40, 32'hC0);
    issue(ffra_pkg::OP_ALLOC, 32'h0, 32'h103);
    drain();
    set_capacity(32'h0);
    issue(ffra_pkg::OP_ALLOC, 32'h0, 32'h1);
    issue(ffra_pkg::OP_FREE, 32'h0, 32'h1);
    set_capacity(32'hFFFFFFFF);
    issue(ffra_pkg::OP_ALLOC, 32'h0, 32'h10);
    issue(ffra_pkg::OP_FREE, 32'h0, 32'h10);
    issue(ffra_pkg::OP_FREE, 32'hFFFFFFFF, 32'h5);
    issue(ffra_pkg::OP_FREE, 32'hFFFFFFF0, 32'h10);
    issue(ffra_pkg::OP_ALLOC, 32'h0, 32'hFFFFFFFF);
    issue(ffra_pkg::OP_ALLOC, 32'h0, 32'hFFFFFFFF);
    issue(ffra_pkg::OP_FREE, 32'h0, 32'hFFFFFFFF);

    // fill the table with isolated ranges, then merge into it
    set_capacity(32'd10);
    for (int unsigned k = 0; k < 70; k++)
      issue(ffra_pkg::OP_FREE, 32'd100 + k * 4 + $urandom_range(0, 1), 32'd1);
    issue(ffra_pkg::OP_FREE, 32'd11, 32'd2);
    issue(ffra_pkg::OP_FREE, 32'd10, 32'd1);
    issue(ffra_pkg::OP_ALLOC, 32'd0, 32'd1);
    issue(ffra_pkg::OP_FREE, 32'd50000, 32'd7);
    random_phase(32'd10, 40);

    // random phases over a range of capacities
    set_capacity(ffra_pkg::CAPACITY_RESET);
    random_phase(ffra_pkg::CAPACITY_RESET, 150);
    set_capacity(32'd1);
    random_phase(32'd1, 80);
    set_capacity(32'd200);
    random_phase(32'd200, 200);
    set_capacity(32'd5000);
    random_phase(32'd5000, 200);
    set_capacity(32'hFFFFFFFF);
    random_phase(32'hFFFFFFFF, 150);
    set_capacity(32'h0);
    random_phase(32'h0, 40);
    set_capacity(32'd3000);
    random_phase(32'd3000, 100);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_grants.size() == 0) begin
      $display("first_fit_range_allocator_unit_tb passed");
    end else begin
      $display("first_fit_range_allocator_unit_tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ffra_pkg.sv
rtl/ffra_ram.sv
rtl/ffra_ctrl.sv
rtl/ffra_dp.sv
rtl/first_fit_range_allocator_unit.sv
tb/sv/first_fit_range_allocator_unit_tb.sv
